// ===== rtl/olt_pkg.sv =====
`default_nettype none

package olt_pkg;

  localparam int unsigned OLT_CAPACITY = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned CountOutW = 5;

  localparam logic [ActionW-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ActionW-1:0] ACT_PREPEND  = 3'd1;
  localparam logic [ActionW-1:0] ACT_ORDERED  = 3'd2;
  localparam logic [ActionW-1:0] ACT_CONTAINS = 3'd3;
  localparam logic [ActionW-1:0] ACT_REMOVE   = 3'd4;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    logic   is_app;
    logic   is_pre;
    logic   is_ord;
    logic   is_eq;
    logic   ins_en;
    logic   rem_en;
    value_t value;
  } olt_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/olt_in_if.sv =====
`default_nettype none

interface olt_in_if
  import olt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/olt_out_if.sv =====
`default_nettype none

interface olt_out_if
  import olt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 dropped;
  logic [CountOutW-1:0] entry_count;

  modport source (output valid, output found, output dropped, output entry_count,
                  input ready);
  modport sink (input valid, input found, input dropped, input entry_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/olt_cell.sv =====
`default_nettype none

module olt_cell
  import olt_pkg::*;
#(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  wire logic            clk_i,
  input  wire olt_ctrl_t       ctrl_i,
  input  wire logic [CntW-1:0] count_i,
  input  wire logic            mark_i,
  input  wire value_t          left_i,
  input  wire value_t          right_i,
  output logic                 mark_o,
  output value_t               entry_o
);

  value_t entry_q;
  value_t entry_d;
  logic   valid;
  logic   less;
  logic   equal;
  logic   hit;

  assign valid = CntW'(Idx) < count_i;
  assign less  = entry_q < ctrl_i.value;
  assign equal = entry_q == ctrl_i.value;

  always_comb begin
    hit = 1'b0;
    if (ctrl_i.is_pre) begin
      hit = 1'b1;
    end else if (ctrl_i.is_app) begin
      hit = !valid;
    end else if (ctrl_i.is_ord) begin
      hit = !valid || !less;
    end else if (ctrl_i.is_eq) begin
      hit = valid && equal;
    end
  end

  assign mark_o = mark_i | hit;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (mark_i) begin
        entry_d = left_i;
      end else if (hit) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.rem_en) begin
      if (mark_o) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_table_unit.sv =====
// A result is registered and valid in the cycle after its item is accepted.
// Throughput: one item per cycle while the result side keeps taking results.
// The cycle is set by the compare-and-mark chain that runs through all cells.
// Reset clears the entry count and the output valid; the entry cells are not
// reset and hold nothing meaningful until written.
`default_nettype none

module ordered_list_table_unit
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = OLT_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  olt_in_if.sink    in_i,
  olt_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  olt_ctrl_t         ctrl;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic              accept;
  logic              is_ins;
  logic              full;
  logic              found;
  logic              out_valid_q;
  logic              found_q;
  logic              dropped_q;
  logic [CntW-1:0]   count_out_q;
  logic [CAPACITY:0] mark;
  value_t            entry [CAPACITY];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = count_q == CntW'(CAPACITY);

  always_comb begin
    ctrl.is_app = in_i.action == ACT_APPEND;
    ctrl.is_pre = in_i.action == ACT_PREPEND;
    ctrl.is_ord = in_i.action == ACT_ORDERED;
    ctrl.is_eq  = (in_i.action == ACT_CONTAINS) || (in_i.action == ACT_REMOVE);
    ctrl.value  = in_i.value;
    is_ins      = ctrl.is_app || ctrl.is_pre || ctrl.is_ord;
    ctrl.ins_en = accept && is_ins && !full;
    ctrl.rem_en = accept && (in_i.action == ACT_REMOVE);
  end

  assign mark[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left;
    value_t right;
    if (i == 0) begin : g_head
      assign left = in_i.value;
    end else begin : g_mid
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = entry[i];
    end else begin : g_body
      assign right = entry[i+1];
    end
    olt_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .mark_i  (mark[i]),
      .left_i  (left),
      .right_i (right),
      .mark_o  (mark[i+1]),
      .entry_o (entry[i])
    );
  end

  assign found = ctrl.is_eq && mark[CAPACITY];

  always_comb begin
    count_d = count_q;
    if (ctrl.ins_en) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem_en && found) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q     <= found;
      dropped_q   <= is_ins && full;
      count_out_q <= count_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = found_q;
  assign out_o.dropped     = dropped_q;
  assign out_o.entry_count = CountOutW'(count_out_q);

endmodule

`default_nettype wire

// ===== sim/ordered_list_table_unit_tb.sv =====
`default_nettype none

module ordered_list_table_unit_tb;
  import olt_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned BlockItems = 40;
  localparam logic [ActionW-1:0] ACT_UNDEF_A = 3'd5;
  localparam logic [ActionW-1:0] ACT_UNDEF_B = 3'd6;
  localparam logic [ActionW-1:0] ACT_UNDEF_C = 3'd7;
  localparam value_t ValueMin = 32'sh8000_0000;
  localparam value_t ValueMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic                 found;
    logic                 dropped;
    logic [CountOutW-1:0] entry_count;
  } list_result_t;

  class list_mirror;
    value_t       contents[$];
    list_result_t awaited[$];
    int unsigned  fail_count;

    function new();
      fail_count = 0;
    endfunction

    function int find_first(value_t v);
      for (int i = 0; i < contents.size(); i++) begin
        if (contents[i] == v) begin
          return i;
        end
      end
      return contents.size();
    endfunction

    function void note_action(logic [ActionW-1:0] act, value_t v);
      list_result_t r;
      int           pos;
      r = '0;
      case (act)
        ACT_APPEND, ACT_PREPEND, ACT_ORDERED: begin
          if (contents.size() >= OLT_CAPACITY) begin
            r.dropped = 1'b1;
          end else if (act == ACT_APPEND) begin
            contents.push_back(v);
          end else if (act == ACT_PREPEND) begin
            contents.push_front(v);
          end else begin
            pos = 0;
            while (pos < contents.size() && contents[pos] < v) begin
              pos++;
            end
            contents.insert(pos, v);
          end
        end
        ACT_CONTAINS: begin
          r.found = find_first(v) < contents.size();
        end
        ACT_REMOVE: begin
          pos = find_first(v);
          if (pos < contents.size()) begin
            r.found = 1'b1;
            contents.delete(pos);
          end
        end
        default: begin
        end
      endcase
      r.entry_count = CountOutW'(contents.size());
      awaited.push_back(r);
    endfunction

    function void check_result(logic found, logic dropped, logic [CountOutW-1:0] count);
      list_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result arrived with no item outstanding");
        fail_count++;
        return;
      end
      exp_r = awaited.pop_front();
      if (found !== exp_r.found) begin
        $error("found mismatch: expected %0b, got %0b", exp_r.found, found);
        fail_count++;
      end
      if (dropped !== exp_r.dropped) begin
        $error("dropped mismatch: expected %0b, got %0b", exp_r.dropped, dropped);
        fail_count++;
      end
      if (count !== exp_r.entry_count) begin
        $error("entry_count mismatch: expected %0d, got %0d", exp_r.entry_count, count);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  olt_in_if  in_if ();
  olt_out_if out_if ();

  ordered_list_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  list_mirror  mirror = new();
  int unsigned cycle_count = 0;
  bit          sender_bursty;
  bit          stall_on = 1'b0;
  int unsigned stall_left = 0;
  value_t      pool[8];

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int unsigned r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        mirror.check_result(out_if.found, out_if.dropped, out_if.entry_count);
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!stall_on) begin
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(6, 25);
        end
      end
      if ($urandom_range(0, 149) == 0) begin
        stall_on = !stall_on;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!sender_bursty) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [ActionW-1:0] act, input value_t v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.value  <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    mirror.note_action(act, v);
  endtask

  function automatic void refill_pool();
    pool[0] = ValueMin;
    pool[1] = ValueMax;
    pool[2] = '0;
    pool[3] = -1;
    for (int i = 4; i < 8; i++) begin
      pool[i] = ($urandom_range(0, 1) == 0) ? value_t'($urandom_range(0, 20)) - 10
                                              : value_t'($urandom);
    end
  endfunction

  task automatic send_random_block(input int unsigned insert_bias);
    int unsigned            r;
    logic [ActionW-1:0]     act;
    value_t                 v;
    logic [ActionW-1:0]     inserts[3];
    logic [ActionW-1:0]     undefs[3];
    inserts = '{ACT_APPEND, ACT_PREPEND, ACT_ORDERED};
    undefs  = '{ACT_UNDEF_A, ACT_UNDEF_B, ACT_UNDEF_C};
    for (int n = 0; n < BlockItems; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        act = undefs[$urandom_range(0, 2)];
      end else if (r < insert_bias) begin
        act = inserts[$urandom_range(0, 2)];
      end else begin
        act = ($urandom_range(0, 1) == 0) ? ACT_CONTAINS : ACT_REMOVE;
      end
      v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : value_t'($urandom);
      send_item(act, v);
    end
  endtask

  initial begin
    int unsigned biases[3];
    biases = '{25, 50, 80};
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.action  = ACT_APPEND;
    in_if.value   = '0;
    sender_bursty = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_CONTAINS, '0);
    send_item(ACT_REMOVE, 32'sd5);
    send_item(ACT_PREPEND, ValueMin);
    send_item(ACT_ORDERED, '0);
    send_item(ACT_ORDERED, -1);
    send_item(ACT_ORDERED, ValueMin);
    send_item(ACT_APPEND, ValueMax);
    send_item(ACT_ORDERED, ValueMax);
    send_item(ACT_CONTAINS, -1);
    send_item(ACT_CONTAINS, 32'sd1);
    send_item(ACT_REMOVE, ValueMin);
    send_item(ACT_REMOVE, 32'sd12345);
    send_item(ACT_UNDEF_A, ValueMax);
    send_item(ACT_UNDEF_B, '0);
    send_item(ACT_UNDEF_C, -1);
    for (int i = 0; i < 11; i++) begin
      send_item(ACT_APPEND, value_t'($urandom));
    end
    send_item(ACT_APPEND, 32'sd7);
    send_item(ACT_PREPEND, 32'sd7);
    send_item(ACT_ORDERED, 32'sd7);

    for (int b = 0; b < RandomItems / BlockItems; b++) begin
      refill_pool();
      sender_bursty = $urandom_range(0, 3) != 0;
      send_random_block(biases[$urandom_range(0, 2)]);
    end
    in_if.valid <= 1'b0;

    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mirror.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ordered_list_table_unit.f =====
rtl/olt_pkg.sv
rtl/olt_in_if.sv
rtl/olt_out_if.sv
rtl/olt_cell.sv
rtl/ordered_list_table_unit.sv
sim/ordered_list_table_unit_tb.sv
